FILE: rtl/sscc_pkg.sv
package sscc_pkg;

    // fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 40;
    localparam int THR_W     = 39;
    localparam int OFFSET_W  = 12;
    localparam int SQ_W      = 80;
    localparam int MAG_W     = 81;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 96;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(800000);
    localparam logic signed [SUM_W-1:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 40'sh80_0000_0000;

    // register index on the configuration port
    localparam logic REG_DETECT_THRESHOLD = 1'b0;

    // input item kinds
    localparam logic OP_REF_WRITE = 1'b0;
    localparam logic OP_CAPTURE   = 1'b1;

    // operand select for the shared squaring unit
    typedef enum logic [1:0] {
        SQ_THR = 2'd0,
        SQ_RE  = 2'd1,
        SQ_IM  = 2'd2
    } t_sq_sel;

    typedef struct packed {
        logic    in_ready;
        logic    search_init;
        logic    sq_load;
        t_sq_sel sq_sel;
        logic    mac_run;
        logic    peak_cmp;
        logic    seq_next;
        logic    emit;
        logic    emit_found;
    } t_cmd;

    typedef struct packed {
        logic start_req;
        logic sq_done;
        logic no_win;
        logic k_last;
        logic mac_done;
        logic j_last;
        logic over;
        logic s_last;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/sscc_cfg.sv
module sscc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [sscc_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  logic [sscc_pkg::APB_DATA_W-1:0]   i_pwdata,
    output logic [sscc_pkg::APB_DATA_W-1:0]   o_prdata,
    output logic                              o_pready,
    output logic [sscc_pkg::THR_W-1:0]        o_threshold
);
    import sscc_pkg::*;

    logic [THR_W-1:0] r_thr;
    logic             w_sel_thr;

    // 64-bit registers at 8-byte spacing
    assign w_sel_thr = (i_paddr[3] == REG_DETECT_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_psel && i_penable && i_pwrite && w_sel_thr) begin
            r_thr <= i_pwdata[THR_W-1:0];
        end
    end

    assign o_prdata    = w_sel_thr ? APB_DATA_W'(r_thr) : '0;
    assign o_pready    = 1'b1;
    assign o_threshold = r_thr;

endmodule

FILE: rtl/sscc_ctrl.sv
module sscc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  sscc_pkg::t_status i_status,
    output sscc_pkg::t_cmd    o_cmd
);
    import sscc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_THR_LOAD = 11'b000_0000_0010,
        S_THR_WAIT = 11'b000_0000_0100,
        S_MAC      = 11'b000_0000_1000,
        S_DRAIN    = 11'b000_0001_0000,
        S_MAG_RE   = 11'b000_0010_0000,
        S_MAG_IM   = 11'b000_0100_0000,
        S_MAG_WAIT = 11'b000_1000_0000,
        S_CMP      = 11'b001_0000_0000,
        S_SEQ_END  = 11'b010_0000_0000,
        S_FINISH   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_found, n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_found = r_found;
        o_cmd   = '0;
        o_cmd.sq_sel     = SQ_THR;
        o_cmd.emit_found = r_found;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid && i_status.start_req) begin
                    n_state = S_THR_LOAD;
                end
            end
            S_THR_LOAD: begin
                o_cmd.search_init = 1'b1;
                o_cmd.sq_load     = 1'b1;
                n_found           = 1'b0;
                n_state           = S_THR_WAIT;
            end
            S_THR_WAIT: begin
                if (i_status.sq_done) begin
                    n_state = i_status.no_win ? S_FINISH : S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.mac_run = 1'b1;
                if (i_status.k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_status.mac_done) begin
                    n_state = S_MAG_RE;
                end
            end
            S_MAG_RE: begin
                o_cmd.sq_load = 1'b1;
                o_cmd.sq_sel  = SQ_RE;
                n_state       = S_MAG_IM;
            end
            S_MAG_IM: begin
                o_cmd.sq_load = 1'b1;
                o_cmd.sq_sel  = SQ_IM;
                n_state       = S_MAG_WAIT;
            end
            S_MAG_WAIT: begin
                if (i_status.sq_done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.peak_cmp = 1'b1;
                n_state = i_status.j_last ? S_SEQ_END : S_MAC;
            end
            S_SEQ_END: begin
                if (i_status.over) begin
                    n_found = 1'b1;
                    n_state = S_FINISH;
                end else if (i_status.s_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.seq_next = 1'b1;
                    n_state        = S_MAC;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a result leaves only from the finish state
    a_emit_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == S_FINISH))
        else $error("emit outside finish");

    // input is taken only while no search is running
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.in_ready |-> !o_cmd.mac_run && !o_cmd.sq_load)
        else $error("input taken during search");

    // found can only be set at the end of a sequence pass
    a_found_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_found) |-> $past(r_state) == S_SEQ_END)
        else $error("found set outside sequence end");

endmodule

FILE: rtl/sscc_dp.sv
module sscc_dp #(
    parameter int REF_LEN       = 128,
    parameter int CAPTURE_DEPTH = 4096,
    parameter int NUM_SEQUENCES = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sscc_pkg::t_cmd                    i_cmd,
    output sscc_pkg::t_status                 o_status,
    input  logic [sscc_pkg::THR_W-1:0]        i_threshold,
    input  logic                              i_in_valid,
    input  logic                              i_in_op,
    input  logic                              i_in_last,
    input  logic [1:0]                        i_in_seq,
    input  logic [6:0]                        i_in_idx,
    input  logic signed [sscc_pkg::SAMPLE_W-1:0] i_in_re,
    input  logic signed [sscc_pkg::SAMPLE_W-1:0] i_in_im,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [1:0]                        o_reached,
    output logic [sscc_pkg::OFFSET_W-1:0]     o_offset,
    output logic signed [sscc_pkg::SUM_W-1:0] o_peak_re,
    output logic signed [sscc_pkg::SUM_W-1:0] o_peak_im,
    output logic                              o_overflow
);
    import sscc_pkg::*;

    localparam int REF_DEPTH = NUM_SEQUENCES * REF_LEN;
    localparam int REF_AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int CAP_AW = $clog2(CAPTURE_DEPTH);
    localparam int CNT_W  = $clog2(CAPTURE_DEPTH + 1);
    localparam int K_W    = (REF_LEN > 1) ? $clog2(REF_LEN) : 1;
    localparam int S_W    = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
    localparam int ACC_W  = 2 * SAMPLE_W + 2 + K_W;
    localparam int SAT_W  = (ACC_W > SUM_W) ? ACC_W : SUM_W;
    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(SUM_MAX);
    localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(SUM_MIN);

    // stores
    logic [2*SAMPLE_W-1:0] r_ref_mem [REF_DEPTH];
    logic [2*SAMPLE_W-1:0] r_cap_mem [CAPTURE_DEPTH];

    logic [CNT_W-1:0]  r_cap_cnt;
    logic              r_ovf;
    logic [K_W-1:0]    r_k;
    logic [CAP_AW-1:0] r_j;
    logic [S_W-1:0]    r_s;
    logic [REF_AW-1:0] r_base;

    // mac pipeline
    logic                       r_v1, r_v2, r_first1, r_first2, r_last1, r_last2;
    logic                       r_mac_done;
    logic [2*SAMPLE_W-1:0]      r_cap_q, r_ref_q;
    logic signed [2*SAMPLE_W:0] r_p_re, r_p_im;
    logic signed [ACC_W-1:0]    r_acc_re, r_acc_im;

    // squaring unit
    logic [SUM_W-1:0] r_sq_op;
    logic             r_sq_v1, r_sq_v2, r_sq_v3;
    t_sq_sel          r_sq_t1, r_sq_t2, r_sq_t3;
    logic [63:0]      r_pll;
    logic [39:0]      r_phl;
    logic [15:0]      r_phh;
    logic [SQ_W-1:0]  r_thr2;
    logic [MAG_W-1:0] r_mag;

    // peak
    logic [MAG_W-1:0]        r_peak_mag;
    logic signed [SUM_W-1:0] r_peak_re, r_peak_im;
    logic [CAP_AW-1:0]       r_peak_pos;

    logic                    w_in_acc, w_ref_ok, w_k_last, w_j_last;
    logic [REF_AW-1:0]       w_ref_wa;
    logic [CAP_AW-1:0]       w_win_last;
    logic signed [SAT_W-1:0] w_ext_re, w_ext_im;
    logic signed [SUM_W-1:0] w_sat_re, w_sat_im;
    logic [SUM_W-1:0]        w_abs_re, w_abs_im;
    logic [SQ_W-1:0]         w_sq;
    logic signed [SAMPLE_W-1:0] w_cre, w_cim, w_rre, w_rim;

    assign w_in_acc = i_in_valid && i_cmd.in_ready;
    assign w_ref_ok = (int'(i_in_seq) < NUM_SEQUENCES) && (int'(i_in_idx) < REF_LEN);
    assign w_ref_wa = REF_AW'(int'(i_in_seq) * REF_LEN + int'(i_in_idx));

    // store writes
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_op == OP_REF_WRITE && w_ref_ok) begin
            r_ref_mem[w_ref_wa] <= {i_in_im, i_in_re};
        end
        if (w_in_acc && i_in_op == OP_CAPTURE && int'(r_cap_cnt) < CAPTURE_DEPTH) begin
            r_cap_mem[r_cap_cnt[CAP_AW-1:0]] <= {i_in_im, i_in_re};
        end
    end

    // capture fill and overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_cnt <= '0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.emit) begin
            r_cap_cnt <= '0;
            r_ovf     <= 1'b0;
        end else if (w_in_acc && i_in_op == OP_CAPTURE) begin
            if (int'(r_cap_cnt) < CAPTURE_DEPTH) begin
                r_cap_cnt <= r_cap_cnt + CNT_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    assign w_win_last = CAP_AW'(32'(r_cap_cnt) - 32'(REF_LEN));
    assign w_k_last   = (r_k == K_W'(REF_LEN - 1));
    assign w_j_last   = (r_j == w_win_last);

    // search counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_j    <= '0;
            r_s    <= '0;
            r_base <= '0;
        end else if (i_cmd.search_init) begin
            r_k    <= '0;
            r_j    <= '0;
            r_s    <= '0;
            r_base <= '0;
        end else begin
            if (i_cmd.mac_run) begin
                r_k <= w_k_last ? '0 : r_k + K_W'(1);
            end
            if (i_cmd.peak_cmp && !w_j_last) begin
                r_j <= r_j + CAP_AW'(1);
            end
            if (i_cmd.seq_next) begin
                r_j    <= '0;
                r_s    <= r_s + S_W'(1);
                r_base <= r_base + REF_AW'(REF_LEN);
            end
        end
    end

    // registered store reads
    always_ff @(posedge i_clk) begin
        r_cap_q <= r_cap_mem[r_j + CAP_AW'(r_k)];
        r_ref_q <= r_ref_mem[r_base + REF_AW'(r_k)];
    end

    assign w_cre = r_cap_q[SAMPLE_W-1:0];
    assign w_cim = r_cap_q[2*SAMPLE_W-1:SAMPLE_W];
    assign w_rre = r_ref_q[SAMPLE_W-1:0];
    assign w_rim = r_ref_q[2*SAMPLE_W-1:SAMPLE_W];

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_mac_done <= 1'b0;
        end else begin
            r_v1       <= i_cmd.mac_run;
            r_v2       <= r_v1;
            r_mac_done <= r_v2 && r_last2;
        end
    end

    // complex product and accumulate
    always_ff @(posedge i_clk) begin
        r_first1 <= (r_k == '0);
        r_last1  <= w_k_last;
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        if (r_v1) begin
            r_p_re <= (2*SAMPLE_W+1)'(w_cre * w_rre) - (2*SAMPLE_W+1)'(w_cim * w_rim);
            r_p_im <= (2*SAMPLE_W+1)'(w_cim * w_rre) + (2*SAMPLE_W+1)'(w_cre * w_rim);
        end
        if (r_v2) begin
            r_acc_re <= r_first2 ? ACC_W'(r_p_re) : r_acc_re + ACC_W'(r_p_re);
            r_acc_im <= r_first2 ? ACC_W'(r_p_im) : r_acc_im + ACC_W'(r_p_im);
        end
    end

    // saturate sums to 40 bits, then magnitude operands
    assign w_ext_re = SAT_W'(r_acc_re);
    assign w_ext_im = SAT_W'(r_acc_im);
    assign w_sat_re = (w_ext_re > SAT_MAX) ? SUM_MAX :
                      (w_ext_re < SAT_MIN) ? SUM_MIN : w_ext_re[SUM_W-1:0];
    assign w_sat_im = (w_ext_im > SAT_MAX) ? SUM_MAX :
                      (w_ext_im < SAT_MIN) ? SUM_MIN : w_ext_im[SUM_W-1:0];
    assign w_abs_re = w_sat_re[SUM_W-1] ? (~w_sat_re + SUM_W'(1)) : w_sat_re;
    assign w_abs_im = w_sat_im[SUM_W-1] ? (~w_sat_im + SUM_W'(1)) : w_sat_im;

    // squaring unit valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v1 <= 1'b0;
            r_sq_v2 <= 1'b0;
            r_sq_v3 <= 1'b0;
        end else begin
            r_sq_v1 <= i_cmd.sq_load;
            r_sq_v2 <= r_sq_v1;
            r_sq_v3 <= r_sq_v2;
        end
    end

    assign w_sq = (SQ_W'(r_phh) << 64) + (SQ_W'(r_phl) << 33) + SQ_W'(r_pll);

    // square split as 8-bit high and 32-bit low halves; partial products
    // line up with the second valid stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_load) begin
            case (i_cmd.sq_sel)
                SQ_THR:  r_sq_op <= SUM_W'(i_threshold);
                SQ_RE:   r_sq_op <= w_abs_re;
                SQ_IM:   r_sq_op <= w_abs_im;
                default: r_sq_op <= '0;
            endcase
            r_sq_t1 <= i_cmd.sq_sel;
        end
        r_pll   <= r_sq_op[31:0] * r_sq_op[31:0];
        r_phl   <= r_sq_op[39:32] * r_sq_op[31:0];
        r_phh   <= r_sq_op[39:32] * r_sq_op[39:32];
        r_sq_t2 <= r_sq_t1;
        r_sq_t3 <= r_sq_t2;
        if (r_sq_v2) begin
            case (r_sq_t2)
                SQ_THR:  r_thr2 <= w_sq;
                SQ_RE:   r_mag  <= MAG_W'(w_sq);
                SQ_IM:   r_mag  <= r_mag + MAG_W'(w_sq);
                default: r_mag  <= r_mag;
            endcase
        end
    end

    // running peak, kept across sequences
    always_ff @(posedge i_clk) begin
        if (i_cmd.search_init) begin
            r_peak_mag <= '0;
            r_peak_re  <= '0;
            r_peak_im  <= '0;
            r_peak_pos <= '0;
        end else if (i_cmd.peak_cmp && r_mag > r_peak_mag) begin
            r_peak_mag <= r_mag;
            r_peak_re  <= w_sat_re;
            r_peak_im  <= w_sat_im;
            r_peak_pos <= r_j;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_found    <= i_cmd.emit_found;
            o_reached  <= i_cmd.emit_found ? 2'(r_s) : 2'(NUM_SEQUENCES - 1);
            o_offset   <= OFFSET_W'(r_peak_pos);
            o_peak_re  <= r_peak_re;
            o_peak_im  <= r_peak_im;
            o_overflow <= r_ovf;
        end
    end

    always_comb begin
        o_status           = '0;
        o_status.start_req = (i_in_op == OP_CAPTURE) && i_in_last;
        o_status.sq_done   = r_sq_v3 && (r_sq_t3 != SQ_RE);
        o_status.no_win    = int'(r_cap_cnt) < REF_LEN;
        o_status.k_last    = w_k_last;
        o_status.mac_done  = r_mac_done;
        o_status.j_last    = w_j_last;
        o_status.over      = r_peak_mag > MAG_W'(r_thr2);
        o_status.s_last    = (r_s == S_W'(NUM_SEQUENCES - 1));
        o_status.out_free  = !o_out_valid || i_out_ready;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cap_cnt) <= CAPTURE_DEPTH)
        else $error("capture count past depth");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten");

    a_peak_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.peak_cmp |=> r_peak_mag >= $past(r_peak_mag))
        else $error("peak magnitude fell");

    a_cmp_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.peak_cmp |-> !r_v1 && !r_v2 && !r_sq_v1 && !r_sq_v2 && !r_sq_v3)
        else $error("compare while pipeline busy");

endmodule

FILE: rtl/sync_sequence_sliding_correlator_core.sv
// Sliding cross-correlator for synchronization sequences. Reference writes
// and capture samples are taken one beat per cycle while the block is idle;
// the capture beat marked tlast starts a search, during which s_axis_tready
// stays low. Each window runs REF_LEN products through the single complex
// multiply-accumulate (one capture and one reference store read per
// cycle), then pipeline drain, squaring and peak compare, and each
// sequence pass ends with the threshold check. A pass has W = stored
// samples - REF_LEN + 1 windows; detection can stop the search early. The
// result beat waits in an output register; new input is taken meanwhile.
module sync_sequence_sliding_correlator_core #(
    parameter int REF_LEN       = 128,
    parameter int CAPTURE_DEPTH = 4096,
    parameter int NUM_SEQUENCES = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: ref_sequence[1:0], ref_index[8:2], sample_re[24:9], sample_im[40:25], zero pad
    input  logic [sscc_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // tuser: operation[0]
    input  logic                                i_s_axis_tuser,
    input  logic                                i_s_axis_tlast,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: found[0], sequence_reached[2:1], peak_offset[14:3], peak_re[54:15],
    //        peak_im[94:55], capture_overflow[95]
    output logic [sscc_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // configuration
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [sscc_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [sscc_pkg::APB_DATA_W-1:0]     i_pwdata,
    output logic [sscc_pkg::APB_DATA_W-1:0]     o_prdata,
    output logic                                o_pready
);
    import sscc_pkg::*;

    t_cmd                    w_cmd;
    t_status                 w_status;
    logic [THR_W-1:0]        w_thr;
    logic                    w_found, w_ovf;
    logic [1:0]              w_reached;
    logic [OFFSET_W-1:0]     w_offset;
    logic signed [SUM_W-1:0] w_pre, w_pim;

    sscc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (i_psel),
        .i_penable   (i_penable),
        .i_pwrite    (i_pwrite),
        .i_paddr     (i_paddr),
        .i_pwdata    (i_pwdata),
        .o_prdata    (o_prdata),
        .o_pready    (o_pready),
        .o_threshold (w_thr)
    );

    sscc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sscc_dp #(
        .REF_LEN       (REF_LEN),
        .CAPTURE_DEPTH (CAPTURE_DEPTH),
        .NUM_SEQUENCES (NUM_SEQUENCES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_threshold (w_thr),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_op     (i_s_axis_tuser),
        .i_in_last   (i_s_axis_tlast),
        .i_in_seq    (i_s_axis_tdata[1:0]),
        .i_in_idx    (i_s_axis_tdata[8:2]),
        .i_in_re     (i_s_axis_tdata[24:9]),
        .i_in_im     (i_s_axis_tdata[40:25]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_found     (w_found),
        .o_reached   (w_reached),
        .o_offset    (w_offset),
        .o_peak_re   (w_pre),
        .o_peak_im   (w_pim),
        .o_overflow  (w_ovf)
    );

    assign o_s_axis_tready = w_cmd.in_ready;
    assign o_m_axis_tdata  = {w_ovf, w_pim, w_pre, w_offset, w_reached, w_found};

endmodule

FILE: dv/sync_sequence_sliding_correlator_core_tb.sv
module sync_sequence_sliding_correlator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sscc_pkg::*;

    localparam int REF_LEN       = 128;
    localparam int CAPTURE_DEPTH = 4096;
    localparam int NUM_SEQUENCES = 3;
    localparam int STALL_LIMIT   = 8_000_000;

    typedef struct {
        logic                       op;
        logic [1:0]                 seq;
        logic [6:0]                 idx;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       last;
    } sample_beat_t;

    typedef struct {
        logic                      found;
        logic [1:0]                reached;
        logic [OFFSET_W-1:0]       offset;
        logic signed [SUM_W-1:0]   pk_re;
        logic signed [SUM_W-1:0]   pk_im;
        logic                      overflow;
    } detect_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_DATA_W-1:0]    in_data = '0;
    logic                    in_user = 1'b0;
    logic                    in_last = 1'b0;
    logic                    o_m_axis_tvalid;
    logic                    out_ready = 1'b0;
    logic [OUT_DATA_W-1:0]   o_m_axis_tdata;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   o_prdata;
    logic                    o_pready;

    sync_sequence_sliding_correlator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_user),
        .i_s_axis_tlast  (in_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [SAMPLE_W-1:0] ref_re_mem [NUM_SEQUENCES*REF_LEN];
    logic signed [SAMPLE_W-1:0] ref_im_mem [NUM_SEQUENCES*REF_LEN];
    logic signed [SAMPLE_W-1:0] cap_re_mem [CAPTURE_DEPTH];
    logic signed [SAMPLE_W-1:0] cap_im_mem [CAPTURE_DEPTH];
    int                         cap_count = 0;
    logic                       cap_overflow = 1'b0;
    logic [THR_W-1:0]           threshold = THR_RESET;

    sample_beat_t pending_beats[$];
    detect_t      detect_expect[$];
    int           err_count = 0;
    int           detect_seen = 0;
    int           idle_cycles = 0;
    bit           run_done = 1'b0;
    bit           no_idle = 1'b0;
    bit           in_taken = 1'b0;
    int           in_gap = 0;
    int           out_stall = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SUM_W-1:0] clip40(longint v);
        if (v > longint'(SUM_MAX)) return SUM_MAX;
        if (v < longint'(SUM_MIN)) return SUM_MIN;
        return v[SUM_W-1:0];
    endfunction

    // slide each sequence over the stored capture, running peak kept across sequences
    function automatic detect_t search_capture();
        detect_t         d;
        logic [81:0]     peak_mag, mag, thr2, t;
        logic signed [81:0] xr, xi;
        logic signed [SUM_W-1:0] sr, si;
        longint          acc_re, acc_im, yr, yi, rr, ri;
        int              windows;
        d.found = 1'b0;
        d.reached = 2'(NUM_SEQUENCES - 1);
        d.offset = '0;
        d.pk_re = '0;
        d.pk_im = '0;
        d.overflow = cap_overflow;
        peak_mag = '0;
        t = 82'(threshold);
        thr2 = t * t;
        windows = (cap_count >= REF_LEN) ? cap_count - REF_LEN + 1 : 0;
        for (int s = 0; s < NUM_SEQUENCES; s++) begin
            for (int j = 0; j < windows; j++) begin
                acc_re = 0;
                acc_im = 0;
                for (int k = 0; k < REF_LEN; k++) begin
                    yr = cap_re_mem[j+k];
                    yi = cap_im_mem[j+k];
                    rr = ref_re_mem[s*REF_LEN+k];
                    ri = ref_im_mem[s*REF_LEN+k];
                    acc_re += yr * rr - yi * ri;
                    acc_im += yi * rr + yr * ri;
                end
                sr = clip40(acc_re);
                si = clip40(acc_im);
                xr = sr;
                xi = si;
                mag = xr * xr + xi * xi;
                if (mag > peak_mag) begin
                    peak_mag = mag;
                    d.pk_re = sr;
                    d.pk_im = si;
                    d.offset = OFFSET_W'(j);
                end
            end
            if (peak_mag > thr2) begin
                d.found = 1'b1;
                d.reached = 2'(s);
                break;
            end
        end
        return d;
    endfunction

    // input side: update store, predict a detection on the tlast capture beat
    function automatic void absorb_beat(sample_beat_t b);
        if (b.op == OP_REF_WRITE) begin
            if (b.seq < NUM_SEQUENCES && b.idx < REF_LEN) begin
                ref_re_mem[b.seq*REF_LEN + b.idx] = b.re;
                ref_im_mem[b.seq*REF_LEN + b.idx] = b.im;
            end
            return;
        end
        if (cap_count < CAPTURE_DEPTH) begin
            cap_re_mem[cap_count] = b.re;
            cap_im_mem[cap_count] = b.im;
            cap_count++;
        end else begin
            cap_overflow = 1'b1;
        end
        if (b.last) begin
            detect_expect.push_back(search_capture());
            cap_count = 0;
            cap_overflow = 1'b0;
        end
    endfunction

    // input driver
    always @(negedge i_clk) begin
        sample_beat_t b;
        if (i_rst_n && (!in_valid || in_taken)) begin
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                b = pending_beats.pop_front();
                in_data <= {7'b0, b.im, b.re, b.idx, b.seq};
                in_user <= b.op;
                in_last <= b.last;
                in_valid <= 1'b1;
                in_gap = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            out_stall = pick_gap();
        end
    end

    // monitors and watchdog
    always @(posedge i_clk) begin
        sample_beat_t b;
        detect_t      e;
        detect_t      a;
        bit           busy;
        busy = 1'b0;
        in_taken <= in_valid && o_s_axis_tready;
        if (i_rst_n && in_valid && o_s_axis_tready) begin
            b.seq  = in_data[1:0];
            b.idx  = in_data[8:2];
            b.re   = in_data[24:9];
            b.im   = in_data[40:25];
            b.op   = in_user;
            b.last = in_last;
            absorb_beat(b);
            busy = 1'b1;
        end
        if (i_rst_n && o_m_axis_tvalid && out_ready) begin
            busy = 1'b1;
            detect_seen++;
            a.found    = o_m_axis_tdata[0];
            a.reached  = o_m_axis_tdata[2:1];
            a.offset   = o_m_axis_tdata[14:3];
            a.pk_re    = o_m_axis_tdata[54:15];
            a.pk_im    = o_m_axis_tdata[94:55];
            a.overflow = o_m_axis_tdata[95];
            if (detect_expect.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, o_m_axis_tdata);
                err_count++;
            end else begin
                e = detect_expect.pop_front();
                if (a.found !== e.found)
                    $display("%0t: found exp %0d got %0d", $time, e.found, a.found);
                if (a.reached !== e.reached)
                    $display("%0t: sequence exp %0d got %0d", $time, e.reached, a.reached);
                if (a.offset !== e.offset)
                    $display("%0t: offset exp %0d got %0d", $time, e.offset, a.offset);
                if (a.pk_re !== e.pk_re)
                    $display("%0t: peak_re exp %0d got %0d", $time, e.pk_re, a.pk_re);
                if (a.pk_im !== e.pk_im)
                    $display("%0t: peak_im exp %0d got %0d", $time, e.pk_im, a.pk_im);
                if (a.overflow !== e.overflow)
                    $display("%0t: overflow exp %0d got %0d", $time, e.overflow, a.overflow);
                if (a.found !== e.found || a.reached !== e.reached || a.offset !== e.offset
                    || a.pk_re !== e.pk_re || a.pk_im !== e.pk_im
                    || a.overflow !== e.overflow)
                    err_count++;
            end
        end
        if (psel && penable) busy = 1'b1;
        if (busy || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (!run_done && idle_cycles >= STALL_LIMIT) begin
            $display("[sync_sequence_sliding_correlator_core] ERROR");
            $finish;
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic push_ref(logic [1:0] seq, logic [6:0] idx, logic last);
        sample_beat_t b;
        b.op = OP_REF_WRITE;
        b.seq = seq;
        b.idx = idx;
        b.re = rand_sample();
        b.im = rand_sample();
        b.last = last;
        pending_beats.push_back(b);
    endtask

    // capture of n beats, tlast on the final one, stray reference writes mixed in when noisy
    task automatic push_capture(int n, bit noisy);
        sample_beat_t b;
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 19) == 0)
                push_ref(2'($urandom_range(0, 3)), 7'($urandom), 1'($urandom));
            b.op = OP_CAPTURE;
            b.seq = 2'($urandom);
            b.idx = 7'($urandom);
            b.re = rand_sample();
            b.im = rand_sample();
            b.last = (i == n - 1);
            pending_beats.push_back(b);
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || in_valid || detect_expect.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // register write, then read back
    task automatic set_threshold(logic [THR_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(8 * REG_DETECT_THRESHOLD);
        pwdata <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        threshold = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (o_prdata[THR_W-1:0] !== value) begin
            $display("%0t: threshold read exp %0d got %0d", $time, value,
                     o_prdata[THR_W-1:0]);
            err_count++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int n;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill every reference entry first, plus an ignored write and a tlast-marked rewrite
        for (int s = 0; s < NUM_SEQUENCES; s++)
            for (int k = 0; k < REF_LEN; k++)
                push_ref(2'(s), 7'(k), 1'b0);
        push_ref(2'd3, 7'd5, 1'b0);
        push_ref(2'd1, 7'd127, 1'b1);
        // short capture, exact fit, one extra window, single beat
        push_capture(5, 0);
        push_capture(REF_LEN, 0);
        push_capture(REF_LEN + 1, 0);
        push_capture(1, 0);
        wait_drained();

        set_threshold('0);
        push_capture(REF_LEN + 2, 0);
        wait_drained();
        set_threshold({THR_W{1'b1}});
        push_capture(REF_LEN + 2, 0);
        wait_drained();

        // overrun the capture store; zero threshold stops after the first sequence
        set_threshold('0);
        no_idle = 1'b1;
        push_capture(CAPTURE_DEPTH + 3, 0);
        wait_drained();
        no_idle = 1'b0;

        // random phases
        n = 0;
        while (n < 1400 || detect_seen < 40) begin
            case ($urandom_range(0, 5))
                0: set_threshold(THR_W'($urandom_range(0, 1000)));
                1: set_threshold({THR_W{1'b1}} - THR_W'($urandom_range(0, 3)));
                default: set_threshold(THR_W'({$urandom, $urandom}) >> $urandom_range(3, 8));
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            for (int c = 0; c < 5; c++) begin
                if ($urandom_range(0, 9) < 3) begin
                    push_capture(REF_LEN + $urandom_range(0, 5), 1);
                    n += REF_LEN;
                end else begin
                    push_capture($urandom_range(1, 40), 1);
                    n += 20;
                end
            end
            wait_drained();
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        run_done = 1'b1;
        if (err_count == 0 && detect_expect.size() == 0) begin
            $display("[sync_sequence_sliding_correlator_core] OK");
        end else begin
            $display("[sync_sequence_sliding_correlator_core] ERROR");
        end
        $finish;
    end

endmodule
